@@ rtl/gcm_pkg.sv @@
// ----------------------------------------------------------------------------
// gcm_pkg: shared types and constants of the grain to cluster matcher
// Sizes of the plane and cluster stores, codes, word structs and the control
// and select structs passed between the top level and the plane chain.
// ----------------------------------------------------------------------------
package gcm_pkg;

	localparam int MaxPlanes    = 64;
	localparam int PlaneIdxW    = $clog2(MaxPlanes);
	localparam int PlaneCntW    = PlaneIdxW + 1;
	localparam int MaxClusters  = 4096;
	localparam int ClusterAddrW = $clog2(MaxClusters);
	localparam int ClusterCntW  = ClusterAddrW + 1;

	typedef enum logic [1:0] {
		ACT_BEGIN   = 2'd0,
		ACT_PLANE   = 2'd1,
		ACT_CLUSTER = 2'd2,
		ACT_QUERY   = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_SINGULAR   = 3'd1,
		ST_NO_PLANE   = 3'd2,
		ST_NO_CLUSTER = 3'd3,
		ST_FULL       = 3'd4
	} status_t;

	// Configuration register indexes.
	localparam logic [2:0] CFG_SHRINK   = 3'd0;
	localparam logic [2:0] CFG_XY_TOL   = 3'd1;
	localparam logic [2:0] CFG_Z_TOL    = 3'd2;
	localparam logic [2:0] CFG_TOP      = 3'd3;
	localparam logic [2:0] CFG_BOTTOM   = 3'd4;
	localparam logic [2:0] CFG_CENTER_X = 3'd5;
	localparam logic [2:0] CFG_CENTER_Y = 3'd6;

	typedef struct packed {
		action_t            action;
		logic signed [31:0] mat_a;
		logic signed [31:0] mat_b;
		logic signed [31:0] mat_c;
		logic signed [31:0] mat_d;
		logic signed [31:0] coord_x;
		logic signed [31:0] coord_y;
		logic signed [31:0] coord_z;
	} item_t;

	typedef struct packed {
		status_t                 status;
		logic [PlaneIdxW-1:0]    plane_index;
		logic [ClusterAddrW-1:0] cluster_index;
	} result_t;

	// Broadcast to every plane cell.
	typedef struct packed {
		logic                    clear;
		logic                    load;
		logic                    inc;
		logic                    match_en;
		logic [PlaneIdxW-1:0]    idx;
		logic signed [31:0]      depth;
		logic [ClusterAddrW-1:0] start;
		logic signed [31:0]      query_z;
		logic [10:0]             z_tol;
	} chain_ctrl_t;

	// First matching plane, handed down the chain.
	typedef struct packed {
		logic                    found;
		logic [PlaneIdxW-1:0]    idx;
		logic [ClusterAddrW-1:0] start;
		logic [ClusterCntW-1:0]  count;
	} chain_sel_t;

endpackage

@@ rtl/gcm_cell.sv @@
// ----------------------------------------------------------------------------
// gcm_cell: one plane of the plane chain
// Holds depth, first cluster and cluster count of one plane, checks the grain
// depth against it and passes the first match on to its neighbor.
// ----------------------------------------------------------------------------
module gcm_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  gcm_pkg::chain_ctrl_t          ctrl,
	input  logic [gcm_pkg::PlaneIdxW-1:0] my_idx,
	input  gcm_pkg::chain_sel_t           sel_in,
	output gcm_pkg::chain_sel_t           sel_out
);
	import gcm_pkg::*;

	logic                    valid_q;
	logic                    match_q;
	logic signed [31:0]      depth_q;
	logic [ClusterAddrW-1:0] start_q;
	logic [ClusterCntW-1:0]  count_q;
	logic signed [32:0]      diff;
	logic [32:0]             dmag;
	logic                    mine;

	// Depth distance to the grain.
	assign diff = 33'(depth_q) - 33'(ctrl.query_z);
	assign dmag = diff[32] ? 33'(-diff) : 33'(diff);
	assign mine = (ctrl.idx == my_idx);

	// Control state of the cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			match_q <= 1'b0;
		end else begin
			if (ctrl.clear) begin
				valid_q <= 1'b0;
			end else if (ctrl.load && mine) begin
				valid_q <= 1'b1;
			end
			if (ctrl.match_en) begin
				match_q <= valid_q && (dmag <= 33'(ctrl.z_tol));
			end
		end
	end

	// Plane contents.
	always_ff @(posedge clk) begin
		if (ctrl.load && mine) begin
			depth_q <= ctrl.depth;
			start_q <= ctrl.start;
			count_q <= '0;
		end else if (ctrl.inc && mine) begin
			count_q <= count_q + 1'b1;
		end
	end

	// An earlier match wins; otherwise this cell offers itself.
	always_comb begin
		sel_out = sel_in;
		if (!sel_in.found && match_q) begin
			sel_out.found = 1'b1;
			sel_out.idx   = my_idx;
			sel_out.start = start_q;
			sel_out.count = count_q;
		end
	end

endmodule

@@ rtl/gcm_plane_chain.sv @@
// ----------------------------------------------------------------------------
// gcm_plane_chain: row of plane cells
// Builds the plane store from one cell per plane and returns the first plane
// whose depth lies within tolerance of the grain.
// ----------------------------------------------------------------------------
module gcm_plane_chain (
	input  logic                 clk,
	input  logic                 arst_n,
	input  gcm_pkg::chain_ctrl_t ctrl,
	output gcm_pkg::chain_sel_t  sel
);
	import gcm_pkg::*;

	chain_sel_t link [MaxPlanes+1];

	assign link[0] = '0;

	// Cells are chained from plane zero upward.
	for (genvar i = 0; i < MaxPlanes; i++) begin : g_cell
		gcm_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl    (ctrl),
			.my_idx  (PlaneIdxW'(i)),
			.sel_in  (link[i]),
			.sel_out (link[i+1])
		);
	end

	assign sel = link[MaxPlanes];

endmodule

@@ rtl/gcm_divider.sv @@
// ----------------------------------------------------------------------------
// gcm_divider: 64 bit unsigned restoring divider
// Produces one quotient bit a cycle; done pulses once when the last quotient bit has been shifted in.
// ----------------------------------------------------------------------------
module gcm_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [63:0] divisor,
	output logic        done,
	output logic [63:0] quotient
);
	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [63:0] rem_q;
	logic [63:0] dvd_q;
	logic [63:0] dvs_q;
	logic [64:0] trial;
	logic        fits;

	// Shift in the next dividend bit and try the subtraction.
	assign trial = {rem_q, dvd_q[63]};
	assign fits  = (trial >= {1'b0, dvs_q});

	// Sequencing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == 6'd63);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Data path. The remainder always stays below a nonzero divisor.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? 64'(trial - {1'b0, dvs_q}) : trial[63:0];
			dvd_q <= {dvd_q[62:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

@@ rtl/grain_to_cluster_matcher.sv @@
// ----------------------------------------------------------------------------
// grain_to_cluster_matcher: match track grains to stored clusters
// Inverts the image matrix, stores planes and clusters, answers grain queries.
// ----------------------------------------------------------------------------
// One word is handled at a time and each gives one result word. A begin word
// forms the determinant from multiplier products and checks it; unless it is
// zero, four 64 bit divisions follow in the shared bit-serial divider. A
// query searches all plane cells in parallel, maps the grain with the
// multiplier, then scans the clusters of a matched plane, one read of the
// cluster memory each, until one lies within tolerance. The next word is
// taken while a result still waits at the output.
module grain_to_cluster_matcher (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  gcm_pkg::item_t      item,
	output logic                result_valid,
	input  logic                result_ready,
	output gcm_pkg::result_t    result,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data
);
	import gcm_pkg::*;

	typedef enum logic [17:0] {
		S_IDLE    = 18'h00001,
		S_BEG_MUL = 18'h00002,
		S_BEG_CHK = 18'h00004,
		S_BEG_DVS = 18'h00008,
		S_BEG_DVW = 18'h00010,
		S_PLN_PRE = 18'h00020,
		S_PLN_MUL = 18'h00040,
		S_PLN_FIN = 18'h00080,
		S_CLU     = 18'h00100,
		S_Q_PLANE = 18'h00200,
		S_Q_SEL   = 18'h00400,
		S_Q_MUL   = 18'h00800,
		S_Q_MAP   = 18'h01000,
		S_C_RD    = 18'h02000,
		S_C_CMP1  = 18'h04000,
		S_C_CMP2  = 18'h08000,
		S_C_CMP3  = 18'h10000,
		S_FIN     = 18'h20000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [13:0]        shrink_q;
	logic [11:0]        xy_tol_q;
	logic [10:0]        z_tol_q;
	logic signed [31:0] top_q;
	logic signed [31:0] bottom_q;
	logic signed [31:0] cen_x_q;
	logic signed [31:0] cen_y_q;

	// Input word and working registers.
	logic signed [31:0] a_q, b_q, c_q, d_q, x_q, y_q, z_q;
	logic signed [31:0] inv_q [4];
	logic [2:0]         step_q;
	logic [1:0]         ent_q;
	logic [63:0]        det_q;
	logic signed [65:0] p0_q, sum0_q, sum1_q;
	logic signed [31:0] lim_q;
	logic               in_band_q;
	logic signed [32:0] diff_q;
	logic signed [31:0] cx_q, cy_q, mx_q, my_q;
	logic [ClusterAddrW-1:0] sel_start_q;
	logic [ClusterCntW-1:0]  sel_count_q;
	logic [ClusterCntW-1:0]  k_q;
	logic               pass_q;
	logic [11:0]        dx_q, dy_q;
	logic [23:0]        sqx_q, sqy_q, tsq_q;
	logic [PlaneCntW-1:0]   planes_q;
	logic [ClusterCntW-1:0] clusters_q;
	logic [ClusterCntW-1:0] newest_cnt_q;
	status_t                 res_status_q;
	logic [PlaneIdxW-1:0]    res_pidx_q;
	logic [ClusterAddrW-1:0] res_cidx_q;
	logic               result_valid_q;
	result_t            result_q;

	// Cluster memory.
	logic [63:0] cl_mem [MaxClusters];
	logic [63:0] rd_q;

	// Shared multiplier.
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] mul_p;
	logic signed [65:0] prod_q;

	logic               div_start, div_done;
	logic [63:0]        div_quot;
	logic [63:0]        dmag;
	logic               det_neg;
	logic signed [32:0] num;
	logic [31:0]        nmag;
	logic [63:0]        dividend;
	logic signed [31:0] inv_val;
	logic signed [31:0] depth_val;
	logic signed [32:0] cdx, cdy;
	logic signed [32:0] ddx, ddy;
	logic [32:0]        mdx, mdy;
	logic [ClusterCntW-1:0] addr_sum;
	logic               scan_stop;
	logic               fin_go;
	chain_ctrl_t        ctrl;
	chain_sel_t         sel;

	// Round to nearest by 2^sh with ties away from zero.
	function automatic logic signed [66:0] round_shift(input logic signed [65:0] v,
			input logic [4:0] sh);
		logic [65:0] m;
		logic [65:0] r;
		m = v[65] ? 66'(-v) : 66'(v);
		r = (m + (66'd1 << (sh - 5'd1))) >> sh;
		return v[65] ? -$signed({1'b0, r}) : $signed({1'b0, r});
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [66:0] v);
		if (v > 67'sd2147483647) begin
			return 32'sh7FFFFFFF;
		end else if (v < -67'sd2147483648) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	// Centring saturates symmetrically.
	function automatic logic signed [31:0] sat_centre(input logic signed [32:0] v);
		if (v > 33'sd2147483647) begin
			return 32'sh7FFFFFFF;
		end else if (v < -33'sd2147483647) begin
			return -32'sh7FFFFFFF;
		end
		return v[31:0];
	endfunction

	// Multiplier operands by phase.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (state_q == S_BEG_MUL) begin
			mul_a = (step_q == 3'd0) ? 33'(a_q) : 33'(b_q);
			mul_b = (step_q == 3'd0) ? 33'(d_q) : 33'(c_q);
		end else if (state_q == S_PLN_MUL) begin
			mul_a = diff_q;
			mul_b = {19'b0, shrink_q};
		end else if (state_q == S_Q_MUL) begin
			mul_a = 33'(inv_q[step_q[1:0]]);
			mul_b = step_q[0] ? 33'(cy_q) : 33'(cx_q);
		end
	end
	assign mul_p = mul_a * mul_b;

	always_ff @(posedge clk) begin
		prod_q <= mul_p;
	end

	// Inverse entry: adjugate element over the determinant.
	assign det_neg = det_q[63];
	assign dmag    = det_neg ? (64'd0 - det_q) : det_q;
	always_comb begin
		case (ent_q)
			2'd0:    num = 33'(d_q);
			2'd1:    num = -33'(b_q);
			2'd2:    num = -33'(c_q);
			default: num = 33'(a_q);
		endcase
	end
	assign nmag     = num[32] ? 32'(-num) : 32'(num);
	assign dividend = {nmag, 32'b0} + (dmag >> 1);
	assign div_start = (state_q == S_BEG_DVS);

	gcm_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (dmag),
		.done     (div_done),
		.quotient (div_quot)
	);

	always_comb begin
		if (num[32] != det_neg) begin
			inv_val = (div_quot >= 64'h80000000) ? 32'sh80000000 : -$signed(div_quot[31:0]);
		end else begin
			inv_val = (div_quot > 64'h7FFFFFFF) ? 32'sh7FFFFFFF : $signed(div_quot[31:0]);
		end
	end

	// Depth after the shrinkage correction.
	assign depth_val = in_band_q ? z_q :
		sat32(round_shift(prod_q, 5'd12) + 67'(lim_q));

	// Grain centring and cluster distance.
	assign cdx = 33'(x_q) - 33'(cen_x_q);
	assign cdy = 33'(y_q) - 33'(cen_y_q);
	assign ddx = 33'(mx_q) - 33'($signed(rd_q[63:32]));
	assign ddy = 33'(my_q) - 33'($signed(rd_q[31:0]));
	assign mdx = ddx[32] ? 33'(-ddx) : 33'(ddx);
	assign mdy = ddy[32] ? 33'(-ddy) : 33'(ddy);
	assign addr_sum  = {1'b0, sel_start_q} + k_q;
	assign scan_stop = (k_q >= sel_count_q) || (addr_sum >= ClusterCntW'(MaxClusters));

	// Plane chain control.
	always_comb begin
		ctrl          = '0;
		ctrl.clear    = (state_q == S_BEG_MUL) && (step_q == 3'd0);
		ctrl.load     = (state_q == S_PLN_FIN);
		ctrl.inc      = (state_q == S_CLU) && (planes_q != '0) &&
			(clusters_q < ClusterCntW'(MaxClusters));
		ctrl.match_en = (state_q == S_Q_PLANE);
		ctrl.idx      = (state_q == S_CLU) ? PlaneIdxW'(planes_q - 1'b1) :
			planes_q[PlaneIdxW-1:0];
		ctrl.depth    = depth_val;
		ctrl.start    = clusters_q[ClusterAddrW-1:0];
		ctrl.query_z  = z_q;
		ctrl.z_tol    = z_tol_q;
	end

	gcm_plane_chain u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.sel    (sel)
	);

	assign fin_go     = (state_q == S_FIN) && (!result_valid_q || result_ready);
	assign item_ready = (state_q == S_IDLE);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shrink_q <= 14'd7782;
			xy_tol_q <= 12'd128;
			z_tol_q  <= 11'd51;
			top_q    <= '0;
			bottom_q <= '0;
			cen_x_q  <= '0;
			cen_y_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SHRINK:   shrink_q <= cfg_data[13:0];
				CFG_XY_TOL:   xy_tol_q <= cfg_data[11:0];
				CFG_Z_TOL:    z_tol_q  <= cfg_data[10:0];
				CFG_TOP:      top_q    <= cfg_data;
				CFG_BOTTOM:   bottom_q <= cfg_data;
				CFG_CENTER_X: cen_x_q  <= cfg_data;
				CFG_CENTER_Y: cen_y_q  <= cfg_data;
				default:      ;
			endcase
		end
	end

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			step_q         <= '0;
			ent_q          <= '0;
			planes_q       <= '0;
			clusters_q     <= '0;
			newest_cnt_q   <= '0;
			result_valid_q <= 1'b0;
			for (int i = 0; i < 4; i++) begin
				inv_q[i] <= '0;
			end
		end else begin
			if (fin_go) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					step_q <= '0;
					if (item_valid) begin
						case (item.action)
							ACT_BEGIN:   state_q <= S_BEG_MUL;
							ACT_PLANE:   state_q <= S_PLN_PRE;
							ACT_CLUSTER: state_q <= S_CLU;
							default:     state_q <= S_Q_PLANE;
						endcase
					end
				end
				S_BEG_MUL: begin
					planes_q   <= '0;
					clusters_q <= '0;
					step_q     <= step_q + 1'b1;
					if (step_q == 3'd2) begin
						state_q <= S_BEG_CHK;
					end
				end
				S_BEG_CHK: begin
					ent_q <= '0;
					if (det_q == '0) begin
						for (int i = 0; i < 4; i++) begin
							inv_q[i] <= '0;
						end
						state_q <= S_FIN;
					end else begin
						state_q <= S_BEG_DVS;
					end
				end
				S_BEG_DVS: state_q <= S_BEG_DVW;
				S_BEG_DVW: begin
					if (div_done) begin
						inv_q[ent_q] <= inv_val;
						ent_q        <= ent_q + 1'b1;
						state_q      <= (ent_q == 2'd3) ? S_FIN : S_BEG_DVS;
					end
				end
				S_PLN_PRE: begin
					state_q <= (planes_q >= PlaneCntW'(MaxPlanes)) ? S_FIN : S_PLN_MUL;
				end
				S_PLN_MUL: state_q <= S_PLN_FIN;
				S_PLN_FIN: begin
					planes_q     <= planes_q + 1'b1;
					newest_cnt_q <= '0;
					state_q      <= S_FIN;
				end
				S_CLU: begin
					if (ctrl.inc) begin
						clusters_q   <= clusters_q + 1'b1;
						newest_cnt_q <= newest_cnt_q + 1'b1;
					end
					state_q <= S_FIN;
				end
				S_Q_PLANE: state_q <= S_Q_SEL;
				S_Q_SEL: begin
					step_q  <= '0;
					state_q <= sel.found ? S_Q_MUL : S_FIN;
				end
				S_Q_MUL: begin
					step_q <= step_q + 1'b1;
					if (step_q == 3'd4) begin
						state_q <= S_Q_MAP;
					end
				end
				S_Q_MAP:  state_q <= S_C_RD;
				S_C_RD:   state_q <= scan_stop ? S_FIN : S_C_CMP1;
				S_C_CMP1: state_q <= S_C_CMP2;
				S_C_CMP2: state_q <= S_C_CMP3;
				S_C_CMP3: begin
					if (pass_q && ({1'b0, sqx_q} + {1'b0, sqy_q} <= {1'b0, tsq_q})) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_C_RD;
					end
				end
				S_FIN: begin
					if (fin_go) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Data path registers.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE) begin
			a_q   <= item.mat_a;
			b_q   <= item.mat_b;
			c_q   <= item.mat_c;
			d_q   <= item.mat_d;
			x_q   <= item.coord_x;
			y_q   <= item.coord_y;
			z_q   <= item.coord_z;
		end
		rd_q <= cl_mem[addr_sum[ClusterAddrW-1:0]];
		unique case (state_q)
			S_BEG_MUL: begin
				res_status_q <= ST_OK;
				res_pidx_q   <= '0;
				res_cidx_q   <= '0;
				if (step_q == 3'd1) begin
					p0_q <= prod_q;
				end
				det_q <= 64'(p0_q - prod_q);
			end
			S_BEG_CHK: begin
				if (det_q == '0) begin
					res_status_q <= ST_SINGULAR;
				end
			end
			S_PLN_PRE: begin
				res_status_q <= ST_FULL;
				res_pidx_q   <= '0;
				res_cidx_q   <= '0;
				in_band_q    <= !(z_q > top_q) && !(z_q < bottom_q);
				lim_q        <= (z_q > top_q) ? top_q : bottom_q;
				diff_q       <= 33'(z_q) - ((z_q > top_q) ? 33'(top_q) : 33'(bottom_q));
			end
			S_PLN_FIN: begin
				res_status_q <= ST_OK;
				res_pidx_q   <= planes_q[PlaneIdxW-1:0];
			end
			S_CLU: begin
				res_cidx_q <= '0;
				if (planes_q == '0) begin
					res_status_q <= ST_NO_PLANE;
					res_pidx_q   <= '0;
				end else begin
					res_pidx_q <= PlaneIdxW'(planes_q - 1'b1);
					if (ctrl.inc) begin
						res_status_q <= ST_OK;
						res_cidx_q   <= newest_cnt_q[ClusterAddrW-1:0];
						cl_mem[clusters_q[ClusterAddrW-1:0]] <= {x_q, y_q};
					end else begin
						res_status_q <= ST_FULL;
					end
				end
			end
			S_Q_PLANE: begin
				cx_q <= sat_centre(cdx);
				cy_q <= sat_centre(cdy);
			end
			S_Q_SEL: begin
				res_status_q <= ST_NO_PLANE;
				res_pidx_q   <= sel.found ? sel.idx : '0;
				res_cidx_q   <= '0;
				sel_start_q  <= sel.start;
				sel_count_q  <= sel.count;
			end
			S_Q_MUL: begin
				if (step_q == 3'd1 || step_q == 3'd3) begin
					p0_q <= prod_q;
				end
				if (step_q == 3'd2) begin
					sum0_q <= p0_q + prod_q;
				end
				if (step_q == 3'd4) begin
					sum1_q <= p0_q + prod_q;
				end
			end
			S_Q_MAP: begin
				mx_q <= sat32(round_shift(sum0_q, 5'd16));
				my_q <= sat32(round_shift(sum1_q, 5'd16));
				k_q  <= '0;
			end
			S_C_RD: begin
				res_status_q <= ST_NO_CLUSTER;
			end
			S_C_CMP1: begin
				pass_q <= (mdx <= 33'(xy_tol_q)) && (mdy <= 33'(xy_tol_q));
				dx_q   <= mdx[11:0];
				dy_q   <= mdy[11:0];
			end
			S_C_CMP2: begin
				sqx_q <= dx_q * dx_q;
				sqy_q <= dy_q * dy_q;
				tsq_q <= xy_tol_q * xy_tol_q;
			end
			S_C_CMP3: begin
				if (pass_q && ({1'b0, sqx_q} + {1'b0, sqy_q} <= {1'b0, tsq_q})) begin
					res_status_q <= ST_OK;
					res_cidx_q   <= k_q[ClusterAddrW-1:0];
				end
				k_q <= k_q + 1'b1;
			end
			default: ;
		endcase
		if (fin_go) begin
			result_q.status        <= res_status_q;
			result_q.plane_index   <= res_pidx_q;
			result_q.cluster_index <= res_cidx_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

@@ rtl/gcm_checker.sv @@
// ----------------------------------------------------------------------------
// gcm_checker: port level checks of the grain to cluster matcher
// Watches the top level's handshakes and result words.
// ----------------------------------------------------------------------------
module gcm_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             item_valid,
	input logic             item_ready,
	input gcm_pkg::result_t result,
	input logic             result_valid,
	input logic             result_ready
);
	import gcm_pkg::*;

	// A stalled result word holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result word changed while stalled");

	// One word at a time: the block is busy right after accepting.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("word accepted while busy");

	// A cluster index only comes with success.
	a_cidx: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status != ST_OK |-> result.cluster_index == '0)
		else $error("cluster index on failed word");

	// No plane index without a plane.
	a_pidx: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.status == ST_NO_PLANE || result.status == ST_SINGULAR)
		|-> result.plane_index == '0)
		else $error("plane index without plane");

endmodule

bind grain_to_cluster_matcher gcm_checker u_gcm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_ready   (item_ready),
	.result       (result),
	.result_valid (result_valid),
	.result_ready (result_ready)
);
